// ===== rtl/mab_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the moving-average baseline unit.
// No dependencies.
package mab_pkg;

    localparam int WIN_W      = 9;
    localparam int GAIN_W     = 10;
    localparam int OUT_W      = 24;
    localparam int CFG_DATA_W = 10;
    localparam int CFG_IDX_W  = 1;
    localparam int Q_DEPTH    = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN   = 1'b1;

    localparam logic [WIN_W-1:0]  WIN_RESET  = 9'd16;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 10'd1;

    localparam logic [OUT_W-1:0] OUT_MIN = 24'h800000;
    localparam logic [OUT_W-1:0] OUT_MAX = 24'h7FFFFF;

    typedef struct packed {
        logic full;
        logic empty;
    } mab_q_status_t;

endpackage

// ===== rtl/mab_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mab_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/mab_queue.sv =====
`timescale 1ns / 1ps
// Two-entry queue between the front and the divider back end.
// Depends on mab_pkg.
module mab_queue #(
    parameter int WIDTH = 34
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  logic [WIDTH-1:0]       push_data,
    input  logic                   pop,
    output logic [WIDTH-1:0]       pop_data,
    output mab_pkg::mab_q_status_t status
);
    import mab_pkg::*;

    localparam int PTR_W = $clog2(Q_DEPTH);
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [Q_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data     = mem_reg[rd_ptr_reg];
    assign status.full  = (count_reg == CNT_W'(Q_DEPTH));
    assign status.empty = (count_reg == '0);

endmodule

// ===== rtl/mab_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts samples, keeps the sample ring, running sum and fill count,
// and queues the sum with its divisor. Depends on mab_pkg and mab_ram.
module mab_front #(
    parameter int MAX_WINDOW  = 256,
    parameter int SAMPLE_BITS = 16,
    parameter int SUM_W       = 25,
    parameter int CNT_W       = 9
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [SAMPLE_BITS-1:0]      sample,
    input  logic                        clear,
    input  logic [mab_pkg::WIN_W-1:0]   window,
    input  mab_pkg::mab_q_status_t      q_status,
    output logic                        push,
    output logic [SUM_W-1:0]            push_sum,
    output logic [CNT_W-1:0]            push_count
);
    import mab_pkg::*;

    localparam int PTR_W = $clog2(MAX_WINDOW);
    localparam int CMP_W = (CNT_W > WIN_W) ? CNT_W : WIN_W;
    localparam logic F_IDLE = 1'b0;
    localparam logic F_BUSY = 1'b1;

    logic                   state_reg, state_next;
    logic [SAMPLE_BITS-1:0] sample_reg;
    logic [PTR_W-1:0]       idx_reg;
    logic [SUM_W-1:0]       sum_reg, sum_next;
    logic [CNT_W-1:0]       fill_reg, fill_next;
    logic [PTR_W-1:0]       wptr_reg, wptr_next;

    logic [CMP_W-1:0]       win_wide;
    logic [CNT_W-1:0]       win_eff;
    logic [PTR_W-1:0]       idx_start;
    logic [CNT_W-1:0]       idx_inc;
    logic [PTR_W-1:0]       wptr_step;
    logic [SAMPLE_BITS-1:0] old_sample;
    logic [SUM_W-1:0]       sample_ext, old_ext, sum_upd;
    logic                   win_full;
    logic                   accept, commit;

    always_comb
    begin
        win_wide = CMP_W'(window);
        if (win_wide == '0)
        begin
            win_eff = CNT_W'(1);
        end
        else if (win_wide > CMP_W'(MAX_WINDOW))
        begin
            win_eff = CNT_W'(MAX_WINDOW);
        end
        else
        begin
            win_eff = CNT_W'(win_wide);
        end
    end

    assign s_tready  = (state_reg == F_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign commit    = (state_reg == F_BUSY) && !q_status.full;
    assign idx_start = (CNT_W'(wptr_reg) >= win_eff) ? '0 : wptr_reg;

    mab_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_WINDOW)
    ) u_ring (
        .clk     (clk),
        .wr_en   (commit),
        .wr_addr (idx_reg),
        .wr_data (sample_reg),
        .rd_en   (accept),
        .rd_addr (idx_start),
        .rd_data (old_sample)
    );

    assign win_full   = (fill_reg >= win_eff);
    assign sample_ext = {{(SUM_W-SAMPLE_BITS){sample_reg[SAMPLE_BITS-1]}}, sample_reg};
    assign old_ext    = win_full
                        ? {{(SUM_W-SAMPLE_BITS){old_sample[SAMPLE_BITS-1]}}, old_sample}
                        : '0;
    assign sum_upd    = sum_reg - old_ext + sample_ext;
    assign idx_inc    = CNT_W'(idx_reg) + CNT_W'(1);
    assign wptr_step  = (idx_inc >= win_eff) ? '0 : idx_inc[PTR_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        sum_next   = sum_reg;
        fill_next  = fill_reg;
        wptr_next  = wptr_reg;
        if (clear)
        begin
            state_next = F_IDLE;
            sum_next   = '0;
            fill_next  = '0;
            wptr_next  = '0;
        end
        else if (accept)
        begin
            state_next = F_BUSY;
        end
        else if (commit)
        begin
            state_next = F_IDLE;
            sum_next   = sum_upd;
            fill_next  = win_full ? fill_reg : fill_reg + CNT_W'(1);
            wptr_next  = wptr_step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            sum_reg   <= '0;
            fill_reg  <= '0;
            wptr_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            sum_reg   <= sum_next;
            fill_reg  <= fill_next;
            wptr_reg  <= wptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_reg <= sample;
            idx_reg    <= idx_start;
        end
    end

    assign push       = commit && !clear;
    assign push_sum   = sum_upd;
    assign push_count = win_full ? fill_reg : fill_reg + CNT_W'(1);

endmodule

// ===== rtl/mab_divider.sv =====
`timescale 1ns / 1ps
// Back end: shared restoring divider for sum / count and mean * 2^F / gain,
// sign and saturation, and the output register. Depends on mab_pkg.
module mab_divider #(
    parameter int SUM_W         = 25,
    parameter int CNT_W         = 9,
    parameter int FRACTION_BITS = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  mab_pkg::mab_q_status_t     q_status,
    input  logic [SUM_W+CNT_W-1:0]     q_data,
    output logic                       pop,
    input  logic [mab_pkg::GAIN_W-1:0] gain,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [mab_pkg::OUT_W-1:0]  m_tdata
);
    import mab_pkg::*;

    localparam int DIV_W = SUM_W + FRACTION_BITS;
    localparam int DV_W  = (CNT_W > GAIN_W) ? CNT_W : GAIN_W;
    localparam int CW    = $clog2(DIV_W + 1);
    localparam int CMP_W = ((DIV_W > OUT_W) ? DIV_W : OUT_W) + 1;
    localparam logic [CMP_W-1:0] LIM_NEG = CMP_W'(1) << (OUT_W - 1);

    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_DIV1 = 2'd1;
    localparam logic [1:0] B_DIV2 = 2'd2;
    localparam logic [1:0] B_DONE = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [DV_W-1:0]  rem_reg, rem_next;
    logic [DV_W-1:0]  dvs_reg, dvs_next;
    logic             neg_reg, neg_next;
    logic             out_valid_reg, out_valid_next;
    logic [OUT_W-1:0] out_data_reg;

    logic [SUM_W-1:0] in_sum, in_mag;
    logic [CNT_W-1:0] in_count;
    logic [DV_W:0]    rem_shift, dvs_ext, rem_sub;
    logic             ge;
    logic [DV_W-1:0]  rem_step;
    logic [DIV_W-1:0] quo_step;
    logic             last;
    logic [CMP_W-1:0] q_ext, q_neg;
    logic [OUT_W-1:0] result;
    logic             load_out;

    assign in_sum   = q_data[SUM_W-1:0];
    assign in_count = q_data[SUM_W+CNT_W-1:SUM_W];
    assign in_mag   = in_sum[SUM_W-1] ? (~in_sum + SUM_W'(1)) : in_sum;

    assign rem_shift = {rem_reg, quo_reg[DIV_W-1]};
    assign dvs_ext   = {1'b0, dvs_reg};
    assign rem_sub   = rem_shift - dvs_ext;
    assign ge        = (rem_shift >= dvs_ext);
    assign rem_step  = ge ? rem_sub[DV_W-1:0] : rem_shift[DV_W-1:0];
    assign quo_step  = {quo_reg[DIV_W-2:0], ge};
    assign last      = (cnt_reg == CW'(1));

    assign q_ext = CMP_W'(quo_reg);
    assign q_neg = ~q_ext + CMP_W'(1);

    always_comb
    begin
        if (neg_reg)
        begin
            result = (q_ext > LIM_NEG) ? OUT_MIN : q_neg[OUT_W-1:0];
        end
        else
        begin
            result = (q_ext > LIM_NEG - CMP_W'(1)) ? OUT_MAX : q_ext[OUT_W-1:0];
        end
    end

    assign pop      = (state_reg == B_IDLE) && !q_status.empty;
    assign load_out = (state_reg == B_DONE) && (!out_valid_reg || m_tready);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        dvs_next   = dvs_reg;
        neg_next   = neg_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (pop)
                begin
                    neg_next   = in_sum[SUM_W-1];
                    quo_next   = DIV_W'(in_mag) << FRACTION_BITS;
                    rem_next   = '0;
                    dvs_next   = DV_W'(in_count);
                    cnt_next   = CW'(SUM_W);
                    state_next = B_DIV1;
                end
            end
            B_DIV1:
            begin
                rem_next = rem_step;
                quo_next = quo_step;
                cnt_next = cnt_reg - CW'(1);
                if (last)
                begin
                    quo_next   = DIV_W'(quo_step[SUM_W-1:0]) << FRACTION_BITS;
                    rem_next   = '0;
                    dvs_next   = (gain == '0) ? DV_W'(1) : DV_W'(gain);
                    cnt_next   = CW'(DIV_W);
                    state_next = B_DIV2;
                end
            end
            B_DIV2:
            begin
                rem_next = rem_step;
                quo_next = quo_step;
                cnt_next = cnt_reg - CW'(1);
                if (last)
                begin
                    state_next = B_DONE;
                end
            end
            B_DONE:
            begin
                if (load_out)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
        if (load_out)
        begin
            out_data_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ===== rtl/moving_average_baseline_unit.sv =====
`timescale 1ns / 1ps
// Moving-average baseline unit: a sample stream in, a baseline stream out.
// Depends on mab_pkg, mab_front, mab_queue, mab_divider and mab_ram.
//
// Usage:
//   s_tdata carries one signed sample per transfer; m_tdata carries the mean of
//   the last window_length samples (fewer during warm-up), divided by gain, as
//   signed fixed point with FRACTION_BITS fraction bits, truncated toward zero.
//   The cfg channel writes window_length (index 0) or gain (index 1); cfg_ready
//   is always high. Write only while no sample is in flight. Writing
//   window_length restarts warm-up; writing gain keeps the stored samples.
// Timing:
//   The front reads the ring on accepting a sample, then updates sum and ring;
//   it takes no new sample before that update, which waits while the queue is
//   full. The back end's shared restoring divider takes one quotient bit a
//   cycle: SUM_W steps for sum / count and SUM_W + FRACTION_BITS steps for the
//   gain division, where SUM_W = SAMPLE_BITS + log2(MAX_WINDOW) + 1. The divider
//   sets throughput, popping no new sum until its last result is loaded out.
// Reset:
//   Clears the running sum, fill count and write pointer and loads
//   window_length 16 and gain 1. No clearing pass is needed.
// Stall:
//   A result holds in the output register while m_tready is low; the divider
//   and a two-entry queue keep working behind it, then s_tready drops.
module moving_average_baseline_unit #(
    parameter int MAX_WINDOW    = 256,
    parameter int SAMPLE_BITS   = 16,
    parameter int FRACTION_BITS = 8
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]       s_tdata,   // [SAMPLE_BITS-1:0] sample
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [((mab_pkg::OUT_W+7)/8)*8-1:0]    m_tdata,   // [23:0] baseline
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [mab_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [mab_pkg::CFG_DATA_W-1:0]         cfg_data
);
    import mab_pkg::*;

    localparam int SUM_W = SAMPLE_BITS + $clog2(MAX_WINDOW) + 1;
    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int MO_W  = ((OUT_W + 7) / 8) * 8;

    logic [WIN_W-1:0]       window_reg, window_next;
    logic [GAIN_W-1:0]      gain_reg, gain_next;
    logic                   cfg_write;
    logic                   win_clear;
    logic                   q_push, q_pop;
    logic [SUM_W-1:0]       push_sum;
    logic [CNT_W-1:0]       push_count;
    logic [SUM_W+CNT_W-1:0] q_data;
    mab_q_status_t          q_status;
    logic [OUT_W-1:0]       baseline;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign win_clear = cfg_write && (cfg_index == CFG_WINDOW);

    always_comb
    begin
        window_next = window_reg;
        gain_next   = gain_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_WINDOW: window_next = cfg_data[WIN_W-1:0];
                CFG_GAIN:   gain_next   = cfg_data[GAIN_W-1:0];
                default:    window_next = window_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= WIN_RESET;
            gain_reg   <= GAIN_RESET;
        end
        else
        begin
            window_reg <= window_next;
            gain_reg   <= gain_next;
        end
    end

    mab_front #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS),
        .SUM_W       (SUM_W),
        .CNT_W       (CNT_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .sample     (s_tdata[SAMPLE_BITS-1:0]),
        .clear      (win_clear),
        .window     (window_reg),
        .q_status   (q_status),
        .push       (q_push),
        .push_sum   (push_sum),
        .push_count (push_count)
    );

    mab_queue #(
        .WIDTH (SUM_W + CNT_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data ({push_count, push_sum}),
        .pop       (q_pop),
        .pop_data  (q_data),
        .status    (q_status)
    );

    mab_divider #(
        .SUM_W         (SUM_W),
        .CNT_W         (CNT_W),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_status (q_status),
        .q_data   (q_data),
        .pop      (q_pop),
        .gain     (gain_reg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (baseline)
    );

    assign m_tdata = MO_W'(baseline);

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_status.full)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_status.empty)
        else $error("queue pop while empty");

    a_front_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("front accepted two samples back to back");

    a_divider_busy: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> !q_pop)
        else $error("divider popped while still dividing");

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// Testbench for moving_average_baseline_unit: a directed table, then random phases.
// It checks each m-side transfer against its own prediction or a known table value.
// Depends on mab_pkg and the RTL of the unit.
module tb;

    import mab_pkg::*;

    localparam int     SAMPLE_W     = 16;
    localparam int     RING_DEPTH   = 256;
    localparam int     FRAC_BITS    = 8;
    localparam int     RANDOM_ITEMS = 1150;
    localparam int     CYCLE_LIMIT  = 2000000;
    localparam int     REPORT_MAX   = 10;
    localparam longint BASE_HI      = (longint'(1) <<< (OUT_W - 1)) - 1;
    localparam longint BASE_LO      = -(longint'(1) <<< (OUT_W - 1));

    typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

    typedef struct {
        row_kind_t          kind;
        logic [CFG_IDX_W-1:0] sel;
        int                 val;
        bit                 known;
        int                 baseline;
    } dir_row_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [15:0]          s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [23:0]          m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_WINDOW;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // predictor state
    logic signed [SAMPLE_W-1:0] ring [RING_DEPTH];
    longint                     acc;
    int                         fill;
    int                         wr_ptr;
    logic [WIN_W-1:0]           win_reg;
    logic [GAIN_W-1:0]          gain_reg;

    logic [OUT_W-1:0] baseline_q [$];
    dir_row_t         dir_rows [$];
    bit               row_known;
    int               row_value;
    bit               steady;
    int               errors;
    int               cycles;
    int               sent;

    moving_average_baseline_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int win_in_force(logic [WIN_W-1:0] w);
        if (w == 0)
            return 1;
        if (w > RING_DEPTH)
            return RING_DEPTH;
        return int'(w);
    endfunction

    function automatic void clear_ring();
        foreach (ring[i])
            ring[i] = '0;
        acc    = 0;
        fill   = 0;
        wr_ptr = 0;
    endfunction

    function automatic logic [OUT_W-1:0] advance_baseline(logic signed [SAMPLE_W-1:0] x);
        int     w;
        int     slot;
        longint mean;
        longint g;
        longint res;
        w    = win_in_force(win_reg);
        slot = wr_ptr;
        if (slot >= w)
            slot = 0;
        if (fill < w)
            fill++;
        else
            acc -= longint'(ring[slot]);
        ring[slot] = x;
        acc += longint'(x);
        slot++;
        if (slot >= w)
            slot = 0;
        wr_ptr = slot;
        mean = acc / longint'(fill);
        g    = (gain_reg == 0) ? 64'sd1 : longint'(gain_reg);
        res  = (mean * (longint'(1) <<< FRAC_BITS)) / g;
        if (res < BASE_LO)
            res = BASE_LO;
        if (res > BASE_HI)
            res = BASE_HI;
        return res[OUT_W-1:0];
    endfunction

    function automatic int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 4);
        return $urandom_range(10, 90);
    endfunction

    function automatic logic [15:0] pick_sample();
        int r;
        r = $urandom_range(0, 99);
        if (r < 12)
        begin
            case ($urandom_range(0, 4))
                0:       return 16'h7FFF;
                1:       return 16'h8000;
                2:       return 16'h0000;
                3:       return 16'hFFFF;
                default: return 16'h0001;
            endcase
        end
        if (r < 60)
            return 16'($urandom);
        return 16'($urandom_range(0, 511) - 256);
    endfunction

    function automatic void add_row(row_kind_t kind, logic [CFG_IDX_W-1:0] sel, int val,
                                    bit known, int baseline);
        dir_row_t row;
        row.kind     = kind;
        row.sel      = sel;
        row.val      = val;
        row.known    = known;
        row.baseline = baseline;
        dir_rows.push_back(row);
    endfunction

    // receiver: random stalls, held off entirely during steady stretches
    int ready_hold = 0;
    always @(negedge clk)
    begin
        int r;
        if (steady)
        begin
            m_tready   <= 1'b1;
            ready_hold = 0;
        end
        else if (ready_hold > 0)
            ready_hold--;
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 60)
            begin
                m_tready   <= 1'b1;
                ready_hold = $urandom_range(0, 5);
            end
            else if (r < 92)
            begin
                m_tready   <= 1'b0;
                ready_hold = $urandom_range(0, 3);
            end
            else
            begin
                m_tready   <= 1'b0;
                ready_hold = $urandom_range(20, 120);
            end
        end
    end

    // transfers: check results, predict on accept, track register writes
    always @(posedge clk)
    begin
        logic [OUT_W-1:0] want;
        logic [OUT_W-1:0] got;
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL moving_average_baseline_unit");
            $finish;
        end
        else if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[OUT_W-1:0];
                if (baseline_q.size() == 0)
                begin
                    errors++;
                    if (errors <= REPORT_MAX)
                        $display("[%0t] unexpected baseline %h", $realtime, got);
                end
                else
                begin
                    want = baseline_q.pop_front();
                    if (got !== want)
                    begin
                        errors++;
                        if (errors <= REPORT_MAX)
                            $display("[%0t] baseline mismatch: expected %h, got %h",
                                     $realtime, want, got);
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                want = advance_baseline(s_tdata);
                if (row_known)
                    want = row_value[OUT_W-1:0];
                baseline_q.push_back(want);
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_WINDOW)
                begin
                    win_reg = cfg_data[WIN_W-1:0];
                    clear_ring();
                end
                else if (cfg_index == CFG_GAIN)
                    gain_reg = cfg_data[GAIN_W-1:0];
            end
        end
    end

    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (baseline_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic hold_off(input int n);
        if (n > 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            s_tdata  <= 16'($urandom);
            repeat (n - 1) @(negedge clk);
        end
    endtask

    task automatic push_sample(input logic [15:0] v, input bit known, input int baseline);
        @(negedge clk);
        s_tvalid  <= 1'b1;
        s_tdata   <= v;
        row_known = known;
        row_value = baseline;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] sel, input int value);
        drain();
        repeat (4) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= CFG_DATA_W'(value);
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int len;
        int pause_at;
        int phase;
        int w;
        win_reg  = WIN_RESET;
        gain_reg = GAIN_RESET;
        clear_ring();

        // after reset: window 16, gain 1
        add_row(ROW_SAMPLE, CFG_WINDOW, 0,      1, 0);
        add_row(ROW_SAMPLE, CFG_WINDOW, 32767,  1, 4194048);
        add_row(ROW_SAMPLE, CFG_WINDOW, -32768, 1, 0);
        // single-sample window: full-scale extremes
        add_row(ROW_WRITE,  CFG_WINDOW, 1,      0, 0);
        add_row(ROW_SAMPLE, CFG_WINDOW, -32768, 1, -8388608);
        add_row(ROW_SAMPLE, CFG_WINDOW, 32767,  1, 8388352);
        // zero gain acts as one
        add_row(ROW_WRITE,  CFG_GAIN,   0,      0, 0);
        add_row(ROW_SAMPLE, CFG_WINDOW, 100,    1, 25600);
        // zero window acts as one
        add_row(ROW_WRITE,  CFG_WINDOW, 0,      0, 0);
        add_row(ROW_SAMPLE, CFG_WINDOW, -5,     1, -1280);
        // largest gain, store kept
        add_row(ROW_WRITE,  CFG_GAIN,   1023,   0, 0);
        add_row(ROW_SAMPLE, CFG_WINDOW, -32768, 0, 0);
        add_row(ROW_SAMPLE, CFG_WINDOW, 12345,  0, 0);
        // two-sample window: truncation toward zero and ring wrap
        add_row(ROW_WRITE,  CFG_GAIN,   1,      0, 0);
        add_row(ROW_WRITE,  CFG_WINDOW, 2,      0, 0);
        add_row(ROW_SAMPLE, CFG_WINDOW, -3,     1, -768);
        add_row(ROW_SAMPLE, CFG_WINDOW, 0,      1, -256);
        add_row(ROW_SAMPLE, CFG_WINDOW, 5,      1, 512);
        add_row(ROW_SAMPLE, CFG_WINDOW, -6,     1, 0);
        // oversized window saturates to the ring depth
        add_row(ROW_WRITE,  CFG_WINDOW, 511,    0, 0);
        add_row(ROW_WRITE,  CFG_GAIN,   7,      0, 0);
        add_row(ROW_SAMPLE, CFG_WINDOW, 32767,  0, 0);
        add_row(ROW_SAMPLE, CFG_WINDOW, 32767,  0, 0);
        add_row(ROW_SAMPLE, CFG_WINDOW, -32768, 0, 0);
        add_row(ROW_SAMPLE, CFG_WINDOW, 1,      0, 0);
        add_row(ROW_WRITE,  CFG_WINDOW, 256,    0, 0);
        add_row(ROW_SAMPLE, CFG_WINDOW, 21845,  0, 0);
        add_row(ROW_SAMPLE, CFG_WINDOW, -21846, 0, 0);

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_WRITE)
                write_reg(dir_rows[i].sel, dir_rows[i].val);
            else
            begin
                hold_off(pick_gap());
                push_sample(16'(dir_rows[i].val), dir_rows[i].known, dir_rows[i].baseline);
            end
        end

        phase = 0;
        sent  = 0;
        while (sent < RANDOM_ITEMS)
        begin
            steady = 1'b0;
            if (phase == 0 || $urandom_range(0, 3) != 0)
            begin
                case ($urandom_range(0, 9))
                    0:       w = 0;
                    1:       w = 1;
                    2:       w = 256;
                    3:       w = $urandom_range(257, 511);
                    4, 5:    w = $urandom_range(2, 8);
                    default: w = $urandom_range(9, 255);
                endcase
                write_reg(CFG_WINDOW, w);
            end
            case ($urandom_range(0, 7))
                0:       write_reg(CFG_GAIN, 0);
                1:       write_reg(CFG_GAIN, 1023);
                2, 3:    write_reg(CFG_GAIN, 1);
                default: write_reg(CFG_GAIN, $urandom_range(2, 1022));
            endcase

            w   = win_in_force(win_reg);
            len = $urandom_range(8, 60);
            if (w > 32 && $urandom_range(0, 2) == 0)
                len = w + $urandom_range(4, 40);
            if (len > RANDOM_ITEMS - sent)
                len = RANDOM_ITEMS - sent;
            pause_at = (phase == 0 || $urandom_range(0, 3) == 0) ?
                       $urandom_range(1, 7) : -1;
            steady   = ($urandom_range(0, 4) == 0);

            for (int i = 0; i < len; i++)
            begin
                if (i == pause_at)
                    drain();
                hold_off(pick_gap());
                push_sample(pick_sample(), 1'b0, 0);
                sent++;
            end
            phase++;
        end

        steady = 1'b0;
        drain();
        repeat (80) @(negedge clk);
        if (errors == 0)
            $display("PASS moving_average_baseline_unit");
        else
            $display("FAIL moving_average_baseline_unit");
        $finish;
    end

endmodule

// ===== moving_average_baseline_unit.f =====
rtl/mab_pkg.sv
rtl/mab_ram.sv
rtl/mab_queue.sv
rtl/mab_front.sv
rtl/mab_divider.sv
rtl/moving_average_baseline_unit.sv
bench/tb.sv
